### rtl/sst_pkg.sv
// Package with the shared widths, codes and defaults of the session slot table.
`timescale 1ns / 1ps

package sst_pkg;

    // Default number of session slots
    localparam int DEFAULT_SLOTS = 16;

    // Field widths
    localparam int MODE_W   = 2;
    localparam int ADDR_W   = 8;
    localparam int KEY_W    = 2 * ADDR_W;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 4;

    // Source address sits above the destination in the key
    localparam int KEY_SHIFT = 8;

    // Request codes
    localparam logic [MODE_W-1:0] MODE_OPEN   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLOSE  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OPEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

endpackage

### rtl/session_slot_table.sv
// Session slot table: parallel key compare over all slots with lowest-free allocation.
// Flow: an accepted request is held in the input register and decoded from it; its
//   result is registered in the result register, which drives o_valid.
// Throughput: one request per cycle while the result side does not stall; the result
//   register and input register form a two-deep pipe that holds under output stall.
// Reset: synchronous, active low; clears every used mark and both valid flags.
//   Slot keys are not reset; a key is compared only while its slot is used.
`timescale 1ns / 1ps

module session_slot_table #(
    parameter int SLOTS = sst_pkg::DEFAULT_SLOTS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Request channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [sst_pkg::MODE_W-1:0]   i_mode,
    input  logic [sst_pkg::ADDR_W-1:0]   i_src_addr,
    input  logic [sst_pkg::ADDR_W-1:0]   i_dest_addr,
    // Result channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [sst_pkg::STATUS_W-1:0] o_status,
    output logic [sst_pkg::INDEX_W-1:0]  o_slot_index
);

    import sst_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Pipeline control
    logic                r_in_valid;
    logic                r_out_valid;
    logic                advance;
    logic                load;

    // Input register
    logic [MODE_W-1:0]   r_mode;
    logic [KEY_W-1:0]    r_key;

    // Slot table
    logic [SLOTS-1:0]    r_used;
    logic [KEY_W-1:0]    r_slot_key [SLOTS];

    // Result register
    logic [STATUS_W-1:0] r_status;
    logic [INDEX_W-1:0]  r_index;

    // Lookup results
    logic                hit;
    logic [SLOT_W-1:0]   hit_idx;
    logic                free_ok;
    logic [SLOT_W-1:0]   free_idx;
    logic [STATUS_W-1:0] n_status;
    logic [INDEX_W-1:0]  n_index;
    logic                do_open;
    logic                do_close;

    // Move the held item on when the result register is empty or being taken
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign load    = i_valid && !o_stall;
    assign o_stall = r_in_valid && !advance;

    // Capture the request and form its key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (load) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_mode <= i_mode;
            r_key  <= (KEY_W'(i_src_addr) << KEY_SHIFT) | KEY_W'(i_dest_addr);
        end
    end

    // Compare the key against every used slot; keep the lowest match
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_used[i] && (r_slot_key[i] == r_key)) begin
                hit     = 1'b1;
                hit_idx = SLOT_W'(i);
            end
        end
    end

    // Find the lowest free slot
    always_comb begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_ok  = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    // Decide the result and the table update
    always_comb begin
        n_status = ST_MISS;
        n_index  = '0;
        do_open  = 1'b0;
        do_close = 1'b0;
        unique case (r_mode)
            MODE_OPEN: begin
                if (hit) begin
                    n_status = ST_OPEN;
                end else if (!free_ok) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_OK;
                    n_index  = INDEX_W'(free_idx);
                    do_open  = 1'b1;
                end
            end
            MODE_SEARCH: begin
                if (hit) begin
                    n_status = ST_OK;
                    n_index  = INDEX_W'(hit_idx);
                end
            end
            MODE_CLOSE: begin
                if (hit) begin
                    n_status = ST_OK;
                    n_index  = INDEX_W'(hit_idx);
                    do_close = 1'b1;
                end
            end
            default: begin
                // reserved request: answer as not found, leave the table alone
                n_status = ST_MISS;
            end
        endcase
    end

    // Update the used marks as the item leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (advance) begin
            if (do_open) begin
                r_used[free_idx] <= 1'b1;
            end else if (do_close) begin
                r_used[hit_idx] <= 1'b0;
            end
        end
    end

    // Store the key of a newly opened slot
    always_ff @(posedge i_clk) begin
        if (advance && do_open) begin
            r_slot_key[free_idx] <= r_key;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_status <= n_status;
            r_index  <= n_index;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_slot_index = r_index;

endmodule

### tb/tb_session_slot_table.sv
// Self-checking testbench for the session slot table: open, search and close traffic.
`timescale 1ns / 1ps

module tb_session_slot_table;
    import sst_pkg::*;

    localparam int SLOTS        = DEFAULT_SLOTS;
    localparam int ITEM_TOTAL   = 1250;
    localparam int POOL_SIZE    = 20;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 80;

    // Reserved request code, answered as a miss
    localparam logic [MODE_W-1:0] MODE_RSVD = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  slot;
    } t_reply;

    // Tracks slot occupancy and queues the reply owed for every accepted request
    class slot_table_tracker;
        bit               used [SLOTS];
        logic [KEY_W-1:0] keys [SLOTS];
        t_reply           owed_replies[$];
        int               errors;

        function new();
            foreach (used[i]) begin
                used[i] = 1'b0;
                keys[i] = '0;
            end
            errors = 0;
        endfunction

        function void note_request(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] src,
                                   logic [ADDR_W-1:0] dst);
            logic [KEY_W-1:0] key;
            int               hit;
            int               free_slot;
            t_reply           r;
            key       = (KEY_W'(src) << KEY_SHIFT) | KEY_W'(dst);
            hit       = -1;
            free_slot = -1;
            // Scan downward so the lowest match and lowest free slot win
            for (int i = SLOTS - 1; i >= 0; i--) begin
                if (used[i] && keys[i] == key)
                    hit = i;
                if (!used[i])
                    free_slot = i;
            end
            r.status = ST_MISS;
            r.slot   = '0;
            case (mode)
                MODE_OPEN: begin
                    if (hit >= 0) begin
                        r.status = ST_OPEN;
                    end else if (free_slot < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        used[free_slot] = 1'b1;
                        keys[free_slot] = key;
                        r.status        = ST_OK;
                        r.slot          = INDEX_W'(free_slot);
                    end
                end
                MODE_SEARCH, MODE_CLOSE: begin
                    if (hit >= 0) begin
                        r.status = ST_OK;
                        r.slot   = INDEX_W'(hit);
                        if (mode == MODE_CLOSE)
                            used[hit] = 1'b0;
                    end
                end
                default: ;
            endcase
            owed_replies.push_back(r);
        endfunction

        function void check_reply(logic [STATUS_W-1:0] status, logic [INDEX_W-1:0] slot);
            t_reply want;
            if (owed_replies.size() == 0) begin
                $error("unexpected result: status %0d slot_index %0d", status, slot);
                errors++;
                return;
            end
            want = owed_replies.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                errors++;
            end
            if (slot !== want.slot) begin
                $error("slot_index: expected %0d, actual %0d", want.slot, slot);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [MODE_W-1:0]   i_mode;
    logic [ADDR_W-1:0]   i_src_addr;
    logic [ADDR_W-1:0]   i_dest_addr;
    logic                o_valid;
    logic                i_stall;
    logic [STATUS_W-1:0] o_status;
    logic [INDEX_W-1:0]  o_slot_index;

    slot_table_tracker tracker;
    int                requests_sent;
    int                replies_seen;
    int                cycle_count;
    bit                sender_may_idle;
    logic [ADDR_W-1:0] pool_src [POOL_SIZE];
    logic [ADDR_W-1:0] pool_dst [POOL_SIZE];

    session_slot_table #(
        .SLOTS(SLOTS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_mode      (i_mode),
        .i_src_addr  (i_src_addr),
        .i_dest_addr (i_dest_addr),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_slot_index(o_slot_index)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_session_slot_table: done, errors");
            $finish;
        end
    end

    // Offer one request, with random idle cycles ahead of it, and hold it until taken
    task automatic send_request(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] src,
                                logic [ADDR_W-1:0] dst);
        while (sender_may_idle && $urandom_range(99) < 25) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_mode      <= mode;
        i_src_addr  <= src;
        i_dest_addr <= dst;
        do @(posedge i_clk); while (o_stall);
        tracker.note_request(mode, src, dst);
        requests_sent++;
        @(negedge i_clk);
    endtask

    // Draw a request: mostly keys from a small pool so that hits and a full table occur
    task automatic send_random_request();
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        int                pick;
        int                k;
        pick = $urandom_range(99);
        if (pick < 45)
            mode = MODE_OPEN;
        else if (pick < 70)
            mode = MODE_SEARCH;
        else if (pick < 97)
            mode = MODE_CLOSE;
        else
            mode = MODE_RSVD;
        if ($urandom_range(99) < 85) begin
            k   = $urandom_range(POOL_SIZE - 1);
            src = pool_src[k];
            dst = pool_dst[k];
        end else begin
            src = ADDR_W'($urandom_range(255));
            dst = ADDR_W'($urandom_range(255));
        end
        send_request(mode, src, dst);
    endtask

    // Result side: random stall, one quiet stretch and one long hold-off
    initial begin : result_side
        int hold_left;
        bit hold_done;
        i_stall   = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && replies_seen >= 700) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (replies_seen >= 300 && replies_seen < 550) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < 25);
            end
        end
    end

    // Check each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            tracker.check_reply(o_status, o_slot_index);
            replies_seen++;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_mode          = MODE_OPEN;
        i_src_addr      = '0;
        i_dest_addr     = '0;
        sender_may_idle = 1'b1;
        requests_sent   = 0;
        replies_seen    = 0;
        cycle_count     = 0;
        tracker         = new();
        foreach (pool_src[i]) begin
            pool_src[i] = ADDR_W'($urandom_range(255));
            pool_dst[i] = ADDR_W'($urandom_range(255));
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Extremes, duplicate open, misses, reuse of a freed slot
        send_request(MODE_OPEN,   8'h00, 8'h00);
        send_request(MODE_OPEN,   8'hFF, 8'hFF);
        send_request(MODE_OPEN,   8'h00, 8'h00);
        send_request(MODE_SEARCH, 8'hFF, 8'hFF);
        send_request(MODE_SEARCH, 8'h01, 8'h02);
        send_request(MODE_CLOSE,  8'h00, 8'h00);
        send_request(MODE_CLOSE,  8'h00, 8'h00);
        send_request(MODE_OPEN,   8'h12, 8'h34);
        // Fill the remaining slots, then one open too many
        for (int i = 0; i < SLOTS - 2; i++)
            send_request(MODE_OPEN, ADDR_W'(8'h40 + i), ADDR_W'(8'h5A ^ i));
        send_request(MODE_OPEN,   8'hA5, 8'h5A);
        send_request(MODE_RSVD,   8'h12, 8'h34);
        send_request(MODE_SEARCH, 8'h12, 8'h34);

        while (requests_sent < ITEM_TOTAL) begin
            sender_may_idle = !(requests_sent >= 300 && requests_sent < 550);
            // Let the pipe drain completely once
            if (requests_sent == 900) begin
                while (tracker.owed_replies.size() != 0) begin
                    i_valid <= 1'b0;
                    @(negedge i_clk);
                end
            end
            send_random_request();
        end
        i_valid <= 1'b0;

        while (tracker.owed_replies.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("tb_session_slot_table: done, clean");
        else
            $display("tb_session_slot_table: done, errors");
        $finish;
    end

endmodule

### filelist.f
rtl/sst_pkg.sv
rtl/session_slot_table.sv
tb/tb_session_slot_table.sv
